// ===== sv/mfp_pkg.sv =====
package mfp_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_PCT    = 3'd1,
        MODE_DEC    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_STR    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CMD_FMT = 2'd0,
        CMD_INT = 2'd1,
        CMD_STR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SIGN,
        N_CONV,
        N_EMIT
    } num_state_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_CHAR,
        JOB_NUM
    } job_kind_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } res_t;

    typedef struct packed {
        job_kind_t kind;
        logic      hex;
        res_t      res;
    } job_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } num_out_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'b0000, d};
        end
        else
        begin
            c = CH_UPPER_A + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/mfp_in_if.sv =====
interface mfp_in_if #(
    parameter int ARG_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [7:0]          data_byte;
    logic [ARG_BITS-1:0] arg_value;

    modport source (output valid, output cmd, output data_byte, output arg_value, input ready);
    modport sink   (input valid, input cmd, input data_byte, input arg_value, output ready);
endinterface

// ===== sv/mfp_out_if.sv =====
interface mfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       error;

    modport source (output valid, output out_char, output last, output error, input ready);
    modport sink   (input valid, input out_char, input last, input error, output ready);
endinterface

// ===== sv/mfp_ctrl.sv =====
module mfp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    cmd,
    input  logic [7:0]    data_byte,
    output mfp_pkg::job_t job
);
    import mfp_pkg::*;

    mode_t mode_reg;
    mode_t mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        job.kind     = JOB_NONE;
        job.hex      = 1'b0;
        job.res.ch   = data_byte;
        job.res.last = 1'b1;
        job.res.err  = 1'b0;
        case (mode_reg)
            MODE_PCT:
            begin
                if (cmd != CMD_FMT)
                begin
                    job.kind    = JOB_CHAR;
                    job.res.ch  = CH_NUL;
                    job.res.err = 1'b1;
                end
                else if (data_byte inside {CH_LOWER_D, CH_LOWER_I})
                begin
                    mode_next = MODE_DEC;
                end
                else if (data_byte inside {CH_LOWER_X, CH_UPPER_X})
                begin
                    mode_next = MODE_HEX;
                end
                else if (data_byte == CH_LOWER_S)
                begin
                    mode_next = MODE_STR;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    job.kind  = JOB_CHAR;
                end
            end
            MODE_DEC, MODE_HEX:
            begin
                if (cmd != CMD_INT)
                begin
                    job.kind    = JOB_CHAR;
                    job.res.ch  = CH_NUL;
                    job.res.err = 1'b1;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    job.kind  = JOB_NUM;
                    job.hex   = (mode_reg == MODE_HEX);
                end
            end
            MODE_STR:
            begin
                if (cmd != CMD_STR)
                begin
                    job.kind    = JOB_CHAR;
                    job.res.ch  = CH_NUL;
                    job.res.err = 1'b1;
                end
                else if (data_byte == CH_NUL)
                begin
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    job.kind = JOB_CHAR;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (cmd != CMD_FMT)
                begin
                    job.kind    = JOB_CHAR;
                    job.res.ch  = CH_NUL;
                    job.res.err = 1'b1;
                end
                else if (data_byte == CH_PERCENT)
                begin
                    mode_next = MODE_PCT;
                end
                else
                begin
                    job.kind = JOB_CHAR;
                end
            end
        endcase
    end

endmodule

// ===== sv/mfp_num.sv =====
module mfp_num #(
    parameter int ARG_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                hex,
    input  logic [ARG_BITS-1:0] arg,
    input  logic                grant,
    output mfp_pkg::num_out_t   out_beat,
    output logic                idle
);
    import mfp_pkg::*;

    localparam int DEC_DIGITS = (ARG_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DW         = NDIG * 4;
    localparam int CW         = $clog2(ARG_BITS);
    localparam int DCW        = $clog2(NDIG);

    num_state_t          state_reg, state_next;
    logic                hex_reg, hex_next;
    logic                seen_reg, seen_next;
    logic [ARG_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]       dig_reg, dig_next;
    logic [CW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]      dig_cnt_reg, dig_cnt_next;

    logic                neg;
    logic [ARG_BITS-1:0] mag;
    logic [DW-1:0]       dab;
    logic [3:0]          nib;
    logic                show;

    assign neg  = !hex && arg[ARG_BITS-1];
    assign mag  = neg ? ARG_BITS'(~arg + 1'b1) : arg;
    assign nib  = dig_reg[DW-1 -: 4];
    assign show = seen_reg || (nib != 4'd0) || (dig_cnt_reg == '0);
    assign idle = (state_reg == N_IDLE);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            dab[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                        : dig_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hex_reg     <= hex_next;
        seen_reg    <= seen_next;
        bin_reg     <= bin_next;
        dig_reg     <= dig_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        hex_next          = hex_reg;
        seen_next         = seen_reg;
        bin_next          = bin_reg;
        dig_next          = dig_reg;
        bit_cnt_next      = bit_cnt_reg;
        dig_cnt_next      = dig_cnt_reg;
        out_beat.valid    = 1'b0;
        out_beat.res.ch   = digit_char(nib);
        out_beat.res.last = (dig_cnt_reg == '0);
        out_beat.res.err  = 1'b0;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    hex_next     = hex;
                    seen_next    = 1'b0;
                    bit_cnt_next = CW'(ARG_BITS - 1);
                    dig_cnt_next = DCW'(NDIG - 1);
                    bin_next     = mag;
                    if (hex)
                    begin
                        dig_next   = DW'(arg);
                        state_next = N_EMIT;
                    end
                    else
                    begin
                        dig_next   = '0;
                        state_next = neg ? N_SIGN : N_CONV;
                    end
                end
            end
            N_SIGN:
            begin
                out_beat.valid    = 1'b1;
                out_beat.res.ch   = CH_MINUS;
                out_beat.res.last = 1'b0;
                if (grant)
                begin
                    state_next = N_CONV;
                end
            end
            N_CONV:
            begin
                dig_next     = {dab[DW-2:0], bin_reg[ARG_BITS-1]};
                bin_next     = {bin_reg[ARG_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = N_EMIT;
                end
            end
            N_EMIT:
            begin
                out_beat.valid = show;
                if (!show || grant)
                begin
                    dig_next     = {dig_reg[DW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    seen_next    = seen_reg || show;
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = N_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    a_sign_dec_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_SIGN |-> !hex_reg)
        else $error("sign stage entered for a hex conversion");

    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == N_EMIT && !hex_reg) |-> (dig_reg[DW-1 -: 4] <= 4'd9))
        else $error("decimal digit out of range");

    a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == N_CONV && bit_cnt_reg != '0) |=> state_reg == N_CONV)
        else $error("conversion left early");

endmodule

// ===== sv/mini_format_print_engine.sv =====
// Small printf formatter on a beat stream: format bytes, integer arguments and string bytes
// go in, characters come out, the last one of each item marked. An item that gives a single
// beat, an error beat included, passes through the holding stage and then the output register.
// For a hex argument the number unit walks every nibble slot of its NDIG-digit register, one
// a cycle unless a beat waits for room in the holding stage, leading zeros skipped without a
// beat. A decimal argument, preceded by a minus sign beat when negative, goes through the
// bit-serial binary-to-BCD shift register, which takes one argument bit per cycle, followed
// by one digit per cycle out of the same register unless a beat waits for room in the holding
// stage. A new item is taken once the number unit is idle and the one-beat holding stage in
// front of the output register is empty.
module mini_format_print_engine #(
    parameter int ARG_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mfp_in_if.sink    items,
    mfp_out_if.source chars
);
    import mfp_pkg::*;

    job_t     job;
    num_out_t num_out;
    logic     num_idle;
    logic     accept;
    logic     load_char;
    logic     load_num;
    logic     out_load;
    logic     pend_space;

    logic     pend_valid_reg, pend_valid_next;
    res_t     pend_reg;
    logic     out_valid_reg, out_valid_next;
    res_t     out_reg;

    assign accept      = items.valid && items.ready;
    assign items.ready = !pend_valid_reg && num_idle;
    assign out_load    = pend_valid_reg && (!out_valid_reg || chars.ready);
    assign pend_space  = !pend_valid_reg || out_load;
    assign load_char   = accept && (job.kind == JOB_CHAR);
    assign load_num    = num_out.valid && pend_space;

    mfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (items.cmd),
        .data_byte (items.data_byte),
        .job       (job)
    );

    mfp_num #(
        .ARG_BITS (ARG_BITS)
    ) u_num (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (job.kind == JOB_NUM)),
        .hex      (job.hex),
        .arg      (items.arg_value),
        .grant    (pend_space),
        .out_beat (num_out),
        .idle     (num_idle)
    );

    always_comb
    begin
        pend_valid_next = load_char || load_num || (pend_valid_reg && !out_load);
        out_valid_next  = out_load || (out_valid_reg && !chars.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_char)
        begin
            pend_reg <= job.res;
        end
        else if (load_num)
        begin
            pend_reg <= num_out.res;
        end
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign chars.valid    = out_valid_reg;
    assign chars.out_char = out_reg.ch;
    assign chars.last     = out_reg.last;
    assign chars.error    = out_reg.err;

    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_char && num_out.valid))
        else $error("holding stage loaded from two sources");

    a_num_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && job.kind == JOB_NUM) |=> !num_idle)
        else $error("number unit did not start");

    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !out_load) |=> (pend_valid_reg && $stable(pend_reg)))
        else $error("held beat lost or changed");

endmodule
